[hw/rtl/assert_macros.svh]
// Assertion macros used by the draw engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Asserts that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mfde_pkg.sv]
// Package with the command codes and sequencer states of the draw engine.
package mfde_pkg;

  typedef enum logic [2:0] {
    CMD_POINT  = 3'd0,
    CMD_LINE   = 3'd1,
    CMD_CIRCLE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LSTEP,
    ST_CSTEP,
    ST_CSQ,
    ST_RD,
    ST_MOD,
    ST_CLR,
    ST_OUT
  } state_e;

  localparam int unsigned PixBits = 3;
  localparam int unsigned CoordW = 11;
  localparam int unsigned CircPts = 8;

endpackage

[hw/rtl/mono_framebuffer_draw_engine.sv]
// Top level: sequencer that rasterizes points, lines and circles into a frame store RAM.
// Point and read pass ST_RD and ST_MOD; unknown codes, and lines or circles while disabled,
// go straight to ST_OUT. A line pixel passes ST_LSTEP, ST_RD and ST_MOD, a circle point
// ST_CSTEP, ST_RD and ST_MOD with ST_CSQ after each step of a; off-screen pixels skip ST_MOD.
// One item at a time: the next is accepted in the cycle after the result leaves.
// Reset clears control state and drawing_enabled, then zeroes the store.
module mono_framebuffer_draw_engine #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] x_first_i,
  input  logic [7:0] y_first_i,
  input  logic [7:0] x_second_i,
  input  logic [7:0] y_second_i,
  input  logic [6:0] radius_i,
  input  logic       color_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o,
  output logic [2:0] done_cmd_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned Depth = COLUMNS * PAGES;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CW = mfde_pkg::CoordW;

  mfde_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [AddrW:0]   cnt_q, cnt_d;
  logic             en_q;
  logic [2:0]       cmd_q, cmd_d;
  logic             color_q, color_d;
  logic [7:0]       rb_q, rb_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d, x0_q, x0_d, y0_q, y0_d;
  logic signed [CW-1:0] dx_q, dx_d, dy_q, dy_d, ex_q, ex_d, ey_q, ey_d, dist_q, dist_d;
  logic signed [CW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [CW-1:0] a_q, a_d, b_q, b_d, px_q, px_d, py_q, py_d;
  logic [2:0]       oct_q, oct_d;
  logic [14:0]      rr_q, rr_d, sq_q, sq_d;
  logic [AddrW-1:0] pa_q, pa_d;
  logic [7:0]       pm_q, pm_d;

  logic             we;
  logic [AddrW-1:0] addr;
  logic [7:0]       wdata, rdata;
  logic [AddrW-1:0] pix_addr;

  mfde_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != mfde_pkg::ST_IDLE);
  assign out_valid_o = (state_q == mfde_pkg::ST_OUT);
  assign read_byte_o = rb_q;
  assign done_cmd_o = cmd_q;
  assign cfg_ready_o = 1'b1;

  assign pix_addr = AddrW'(py_q[CW-1:3]) * AddrW'(COLUMNS) + AddrW'(px_q);

  function automatic logic onscr(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    onscr = (x >= 0) && (y >= 0) && (x < $signed(CW'(COLUMNS)))
         && (y < $signed(CW'(8 * PAGES)));
  endfunction

  // Circle octant point selection.
  logic signed [CW-1:0] ox, oy;
  always_comb begin
    ox = x0_q;
    oy = y0_q;
    case (oct_q)
      3'd0: begin ox = x0_q - b_q; oy = y0_q - a_q; end
      3'd1: begin ox = x0_q + b_q; oy = y0_q - a_q; end
      3'd2: begin ox = x0_q - a_q; oy = y0_q + b_q; end
      3'd3: begin ox = x0_q - a_q; oy = y0_q - b_q; end
      3'd4: begin ox = x0_q + b_q; oy = y0_q + a_q; end
      3'd5: begin ox = x0_q + a_q; oy = y0_q - b_q; end
      3'd6: begin ox = x0_q + a_q; oy = y0_q + b_q; end
      default: begin ox = x0_q - b_q; oy = y0_q + a_q; end
    endcase
  end

  logic signed [CW-1:0] ex_n, ey_n, ap1;
  assign ex_n = ex_q + dx_q;
  assign ey_n = ey_q + dy_q;
  assign ap1 = a_q + CW'(1);

  always_comb begin
    logic signed [CW-1:0] ddx, ddy;
    ddx = $signed({3'b0, x_second_i}) - $signed({3'b0, x_first_i});
    ddy = $signed({3'b0, y_second_i}) - $signed({3'b0, y_first_i});
    state_d = state_q; ret_d = ret_q; cnt_d = cnt_q; cmd_d = cmd_q; color_d = color_q;
    rb_d = rb_q; cx_d = cx_q; cy_d = cy_q; x0_d = x0_q; y0_d = y0_q; dx_d = dx_q;
    dy_d = dy_q; ex_d = ex_q; ey_d = ey_q; dist_d = dist_q; sx_d = sx_q; sy_d = sy_q;
    a_d = a_q; b_d = b_q; px_d = px_q; py_d = py_q; oct_d = oct_q; rr_d = rr_q;
    sq_d = sq_q; pa_d = pa_q; pm_d = pm_q;
    case (state_q)
      mfde_pkg::ST_INIT, mfde_pkg::ST_CLR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AddrW+1)'(Depth - 1)) begin
          state_d = (state_q == mfde_pkg::ST_INIT) ? mfde_pkg::ST_IDLE : mfde_pkg::ST_OUT;
        end
      end
      mfde_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_d = cmd_i; color_d = color_i; rb_d = '0; cnt_d = '0;
          x0_d = $signed({3'b0, x_first_i}); y0_d = $signed({3'b0, y_first_i});
          cx_d = $signed({3'b0, x_first_i}); cy_d = $signed({3'b0, y_first_i});
          sx_d = (ddx > 0) ? CW'(1) : (ddx < 0) ? -CW'(1) : '0;
          sy_d = (ddy > 0) ? CW'(1) : (ddy < 0) ? -CW'(1) : '0;
          dx_d = (ddx < 0) ? -ddx : ddx;
          dy_d = (ddy < 0) ? -ddy : ddy;
          dist_d = (dx_d > dy_d) ? dx_d : dy_d;
          ex_d = '0; ey_d = '0; a_d = '0; b_d = $signed({4'b0, radius_i});
          oct_d = '0; rr_d = {8'b0, radius_i} * {8'b0, radius_i};
          state_d = mfde_pkg::ST_OUT;
          case (cmd_i)
            mfde_pkg::CMD_POINT: begin
              px_d = x0_d; py_d = y0_d; ret_d = mfde_pkg::ST_OUT;
              state_d = mfde_pkg::ST_RD;
            end
            mfde_pkg::CMD_LINE: if (en_q) state_d = mfde_pkg::ST_LSTEP;
            mfde_pkg::CMD_CIRCLE: if (en_q) state_d = mfde_pkg::ST_CSTEP;
            mfde_pkg::CMD_READ: begin
              px_d = x0_d; py_d = y0_d; ret_d = mfde_pkg::ST_OUT;
              state_d = mfde_pkg::ST_RD;
            end
            mfde_pkg::CMD_CLEAR: state_d = mfde_pkg::ST_CLR;
            default: state_d = mfde_pkg::ST_OUT;
          endcase
        end
      end
      mfde_pkg::ST_LSTEP: begin
        px_d = cx_q; py_d = cy_q;
        ex_d = (ex_n > dist_q) ? ex_n - dist_q : ex_n;
        ey_d = (ey_n > dist_q) ? ey_n - dist_q : ey_n;
        cx_d = (ex_n > dist_q) ? cx_q + sx_q : cx_q;
        cy_d = (ey_n > dist_q) ? cy_q + sy_q : cy_q;
        cnt_d = cnt_q + 1'b1;
        ret_d = (cnt_q == (AddrW+1)'(dist_q)) ? mfde_pkg::ST_OUT : mfde_pkg::ST_LSTEP;
        state_d = mfde_pkg::ST_RD;
      end
      mfde_pkg::ST_CSTEP: begin
        if (a_q > b_q) begin
          state_d = mfde_pkg::ST_OUT;
        end else begin
          px_d = ox; py_d = oy;
          oct_d = oct_q + 3'd1;
          if (oct_q == 3'd7) begin
            a_d = ap1;
            sq_d = 15'(ap1 * ap1);
            ret_d = mfde_pkg::ST_CSQ;
          end else begin
            ret_d = mfde_pkg::ST_CSTEP;
          end
          state_d = mfde_pkg::ST_RD;
        end
      end
      mfde_pkg::ST_CSQ: begin
        if (16'(sq_q) + 16'(b_q * b_q) > 16'(rr_q)) b_d = b_q - CW'(1);
        state_d = mfde_pkg::ST_CSTEP;
      end
      mfde_pkg::ST_RD: begin
        pa_d = pix_addr;
        pm_d = 8'(1) << py_q[2:0];
        if (cmd_q == mfde_pkg::CMD_READ) begin
          state_d = (px_q < $signed(CW'(COLUMNS)) && py_q[CW-1:3] < PAGES)
                  ? mfde_pkg::ST_MOD : mfde_pkg::ST_OUT;
        end else begin
          state_d = onscr(px_q, py_q) ? mfde_pkg::ST_MOD : ret_q;
        end
      end
      mfde_pkg::ST_MOD: begin
        if (cmd_q == mfde_pkg::CMD_READ) rb_d = rdata;
        state_d = ret_q;
      end
      mfde_pkg::ST_OUT: if (!out_stall_i) state_d = mfde_pkg::ST_IDLE;
      default: state_d = mfde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    addr = pa_q;
    wdata = '0;
    case (state_q)
      mfde_pkg::ST_INIT, mfde_pkg::ST_CLR: begin
        we = 1'b1;
        addr = cnt_q[AddrW-1:0];
      end
      mfde_pkg::ST_RD: begin
        addr = pix_addr;
      end
      mfde_pkg::ST_MOD: begin
        we = (cmd_q != mfde_pkg::CMD_READ);
        wdata = color_q ? (rdata | pm_q) : (rdata & ~pm_q);
      end
      default: addr = pa_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfde_pkg::ST_INIT;
      ret_q <= mfde_pkg::ST_OUT;
      cnt_q <= '0;
      en_q <= 1'b0;
      cmd_q <= '0;
      rb_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      cnt_q <= cnt_d;
      cmd_q <= cmd_d;
      rb_q <= rb_d;
      if (cfg_valid_i && cfg_ready_o) en_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d; cx_q <= cx_d; cy_q <= cy_d; x0_q <= x0_d; y0_q <= y0_d;
    dx_q <= dx_d; dy_q <= dy_d; ex_q <= ex_d; ey_q <= ey_d; dist_q <= dist_d;
    sx_q <= sx_d; sy_q <= sy_d; a_q <= a_d; b_q <= b_d; px_q <= px_d; py_q <= py_d;
    oct_q <= oct_d; rr_q <= rr_d; sq_q <= sq_d; pa_q <= pa_d; pm_q <= pm_d;
  end

  `ASSERT_IMPL(a_we_mod, clk_i, rst_ni, we && !(state_q == mfde_pkg::ST_INIT ||
    state_q == mfde_pkg::ST_CLR), state_q == mfde_pkg::ST_MOD, "write outside modify")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(read_byte_o), "result lost while stalled")
  `ASSERT_IMPL(a_rb_zero, clk_i, rst_ni, out_valid_o && cmd_q != mfde_pkg::CMD_READ,
    read_byte_o == 8'd0, "nonzero byte on non-read")

endmodule

[hw/rtl/mfde_ram.sv]
// Generic single-port RAM with a registered read.
module mfde_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the monochrome frame store draw engine.
`timescale 1ns / 100ps

module tb;

  localparam int Cols = 128;
  localparam int Pages = 8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] xa;
    logic [7:0] ya;
    logic [7:0] xb;
    logic [7:0] yb;
    logic [6:0] radius;
    logic       color;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [2:0] done_cmd;
  } done_t;

  localparam int CmdBits = $bits(draw_cmd_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] cmd_i = '0;
  logic [7:0] x_first_i = '0, y_first_i = '0, x_second_i = '0, y_second_i = '0;
  logic [6:0] radius_i = '0;
  logic color_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] read_byte_o;
  logic [2:0] done_cmd_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;

  mono_framebuffer_draw_engine u_top (.*);

  logic [7:0] shadow_store [Cols*Pages];
  logic       shadow_enabled;
  draw_cmd_t  pending_cmds[$];
  done_t      expected_done[$];
  int         mismatches = 0;
  int         done_count = 0;
  int         in_gap = 0;
  int         out_gap = 0;
  bit         quiet = 1'b0;
  bit         cfg_req = 1'b0;
  logic       cfg_value = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void shadow_plot(int x, int y, bit set);
    int idx;
    if (x < 0 || y < 0 || x >= Cols || y >= 8 * Pages) return;
    idx = (y / 8) * Cols + x;
    if (set) shadow_store[idx] |= 8'(1 << (y % 8));
    else shadow_store[idx] &= ~8'(1 << (y % 8));
  endfunction

  function automatic void shadow_line(int x1, int y1, int x2, int y2, bit set);
    int dx, dy, sx, sy, span, ex, ey, cx, cy;
    dx = x2 - x1; dy = y2 - y1; sx = 0; sy = 0; ex = 0; ey = 0; cx = x1; cy = y1;
    if (dx > 0) sx = 1;
    else if (dx < 0) begin sx = -1; dx = -dx; end
    if (dy > 0) sy = 1;
    else if (dy < 0) begin sy = -1; dy = -dy; end
    span = (dx > dy) ? dx : dy;
    for (int t = 0; t <= span; t++) begin
      shadow_plot(cx, cy, set);
      ex += dx; ey += dy;
      if (ex > span) begin ex -= span; cx += sx; end
      if (ey > span) begin ey -= span; cy += sy; end
    end
  endfunction

  function automatic void shadow_circle(int x0, int y0, int r, bit set);
    int a, b;
    a = 0; b = r;
    while (a <= b) begin
      shadow_plot(x0 - b, y0 - a, set); shadow_plot(x0 + b, y0 - a, set);
      shadow_plot(x0 - a, y0 + b, set); shadow_plot(x0 - a, y0 - b, set);
      shadow_plot(x0 + b, y0 + a, set); shadow_plot(x0 + a, y0 - b, set);
      shadow_plot(x0 + a, y0 + b, set); shadow_plot(x0 - b, y0 + a, set);
      a++;
      if (a * a + b * b > r * r) b--;
    end
  endfunction

  function automatic done_t predict_done(draw_cmd_t c);
    done_t d;
    d.read_byte = '0;
    d.done_cmd = c.cmd;
    case (c.cmd)
      mfde_pkg::CMD_POINT: shadow_plot(c.xa, c.ya, c.color);
      mfde_pkg::CMD_LINE: if (shadow_enabled) shadow_line(c.xa, c.ya, c.xb, c.yb, c.color);
      mfde_pkg::CMD_CIRCLE: if (shadow_enabled) shadow_circle(c.xa, c.ya, c.radius, c.color);
      mfde_pkg::CMD_READ: if (c.xa < Cols && c.ya / 8 < Pages)
        d.read_byte = shadow_store[(c.ya / 8) * Cols + c.xa];
      mfde_pkg::CMD_CLEAR: foreach (shadow_store[i]) shadow_store[i] = '0;
      default: ;
    endcase
    return d;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_done.push_back(predict_done(pending_cmds.pop_front()));
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() > 0 && rst_ni) begin
        in_valid_i <= 1'b1;
        {cmd_i, x_first_i, y_first_i, x_second_i, y_second_i, radius_i, color_i}
          <= pending_cmds[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      done_count++;
      if (expected_done.size() == 0) begin
        report_mismatch("unexpected result cmd", done_cmd_o, -1);
      end else begin
        done_t want;
        want = expected_done.pop_front();
        if (done_cmd_o !== want.done_cmd) report_mismatch("done_cmd", done_cmd_o, want.done_cmd);
        if (read_byte_o !== want.read_byte)
          report_mismatch("read_byte", read_byte_o, want.read_byte);
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) begin
      shadow_enabled = cfg_data_i;
      cfg_valid_i <= 1'b0;
      cfg_req = 1'b0;
    end else if (cfg_req) begin
      cfg_valid_i <= 1'b1;
      cfg_data_i <= cfg_value;
    end
  end

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int sel;
    c = draw_cmd_t'(CmdBits'({$urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 20) c.cmd = mfde_pkg::CMD_POINT;
    else if (sel < 40) c.cmd = mfde_pkg::CMD_LINE;
    else if (sel < 55) c.cmd = mfde_pkg::CMD_CIRCLE;
    else if (sel < 92) c.cmd = mfde_pkg::CMD_READ;
    else if (sel < 93) c.cmd = mfde_pkg::CMD_CLEAR;
    else c.cmd = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 3) != 0) begin
      c.xa = 8'($urandom_range(0, 140));
      c.ya = 8'($urandom_range(0, 70));
      c.xb = 8'($urandom_range(0, 140));
      c.yb = 8'($urandom_range(0, 70));
      c.radius = 7'($urandom_range(0, 40));
    end
    return c;
  endfunction

  task automatic run_phase(bit enable, int count, bit directed);
    draw_cmd_t c;
    while (pending_cmds.size() > 0 || expected_done.size() > 0) @(posedge clk_i);
    repeat (2 * Cols * Pages + 50) @(posedge clk_i);
    cfg_value = enable;
    cfg_req = 1'b1;
    while (cfg_req) @(posedge clk_i);
    if (directed) begin
      pending_cmds.push_back('{mfde_pkg::CMD_POINT, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_POINT, 8'd127, 8'd63, 8'd0, 8'd0, 7'd0, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_POINT, 8'd255, 8'd255, 8'd0, 8'd0, 7'd0, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_POINT, 8'd128, 8'd64, 8'd0, 8'd0, 7'd0, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_LINE, 8'd0, 8'd0, 8'd127, 8'd63, 7'd0, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_LINE, 8'd255, 8'd0, 8'd0, 8'd255, 7'd0, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_LINE, 8'd10, 8'd10, 8'd10, 8'd10, 7'd0, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_CIRCLE, 8'd64, 8'd32, 8'd0, 8'd0, 7'd127, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_CIRCLE, 8'd2, 8'd2, 8'd0, 8'd0, 7'd20, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_CIRCLE, 8'd50, 8'd30, 8'd0, 8'd0, 7'd0, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_LINE, 8'd0, 8'd0, 8'd127, 8'd63, 7'd0, 1'b0});
      pending_cmds.push_back('{mfde_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0, 1'b0});
      pending_cmds.push_back('{mfde_pkg::CMD_READ, 8'd127, 8'd63, 8'd0, 8'd0, 7'd0, 1'b0});
      pending_cmds.push_back('{mfde_pkg::CMD_READ, 8'd128, 8'd0, 8'd0, 8'd0, 7'd0, 1'b0});
      pending_cmds.push_back('{mfde_pkg::CMD_READ, 8'd0, 8'd64, 8'd0, 8'd0, 7'd0, 1'b0});
      pending_cmds.push_back('{mfde_pkg::CMD_READ, 8'd64, 8'd0, 8'd0, 8'd0, 7'd0, 1'b0});
      pending_cmds.push_back('{3'd5, 8'd1, 8'd1, 8'd0, 8'd0, 7'd0, 1'b1});
      pending_cmds.push_back('{3'd7, 8'd1, 8'd1, 8'd0, 8'd0, 7'd0, 1'b1});
      pending_cmds.push_back('{mfde_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0, 1'b0});
      pending_cmds.push_back('{mfde_pkg::CMD_READ, 8'd127, 8'd63, 8'd0, 8'd0, 7'd0, 1'b0});
    end
    for (int i = 0; i < count; i++) begin
      c = random_cmd();
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
    shadow_enabled = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(1'b1, 0, 1'b1);
    run_phase(1'b0, 300, 1'b1);
    run_phase(1'b1, 900, 1'b0);
    run_phase(1'b0, 200, 1'b0);
    run_phase(1'b1, 400, 1'b0);
    while (pending_cmds.size() > 0) @(posedge clk_i);
    quiet = 1'b1;
    run_phase(1'b1, 200, 1'b0);
    while (pending_cmds.size() > 0 || expected_done.size() > 0) @(posedge clk_i);
    repeat (Cols * Pages + 100) @(posedge clk_i);
    $display("Ran %0d commands through point, line, circle, read, clear and unknown codes,",
             done_count);
    $display("with drawing switched on and off and random stalls on both sides.");
    if (mismatches == 0 && expected_done.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("Timeout with %0d results outstanding", expected_done.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mfde_pkg.sv
hw/rtl/mfde_ram.sv
hw/rtl/mono_framebuffer_draw_engine.sv
tb/tb.sv
